// File: design/oads_pkg.sv
// Shared types, constants and helpers for the obstacle avoidance drive sequencer.
// No dependencies; imported by every module of the block.
package oads_pkg;

    localparam int COUNT_WIDTH = 24;
    localparam int TICK_W      = 24;
    localparam int RANGE_W     = 10;
    localparam int DUTY_W      = 8;
    localparam int MODE_W      = 2;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 24;

    localparam logic [CFG_INDEX_W-1:0] CFG_NEAR_THRESHOLD   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BACK_TICKS       = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_TURN_TICKS       = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_CRUISE_DUTY      = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_REVERSE_DUTY     = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_TURN_LEFT_DUTY   = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_TURN_RIGHT_DUTY  = 3'd6;

    localparam logic [MODE_W-1:0] MODE_STOP     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BACK     = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TURN     = 2'd2;
    localparam logic [MODE_W-1:0] MODE_STRAIGHT = 2'd3;

    localparam logic [RANGE_W-1:0]       RST_NEAR_THRESHOLD  = 10'd10;
    localparam logic [TICK_W-1:0]        RST_BACK_TICKS      = 24'd2500000;
    localparam logic [TICK_W-1:0]        RST_TURN_TICKS      = 24'd2500000;
    localparam logic signed [DUTY_W-1:0] RST_CRUISE_DUTY     = 8'sd50;
    localparam logic signed [DUTY_W-1:0] RST_REVERSE_DUTY    = -8'sd30;
    localparam logic signed [DUTY_W-1:0] RST_TURN_LEFT_DUTY  = 8'sd30;
    localparam logic signed [DUTY_W-1:0] RST_TURN_RIGHT_DUTY = 8'sd90;

    typedef enum logic [3:0] {
        ST_STOP     = 4'b0001,
        ST_BACK     = 4'b0010,
        ST_TURN     = 4'b0100,
        ST_STRAIGHT = 4'b1000
    } drive_state_t;

    typedef struct packed {
        logic [RANGE_W-1:0]       near_threshold;
        logic [TICK_W-1:0]        back_ticks;
        logic [TICK_W-1:0]        turn_ticks;
        logic signed [DUTY_W-1:0] cruise_duty;
        logic signed [DUTY_W-1:0] reverse_duty;
        logic signed [DUTY_W-1:0] turn_left_wheel_duty;
        logic signed [DUTY_W-1:0] turn_right_wheel_duty;
    } oads_cfg_t;

    typedef struct packed {
        drive_state_t state;
        logic         count_zero;
    } oads_stat_t;

    // Saturate to the countdown range, and treat zero as one.
    function automatic logic [COUNT_WIDTH-1:0] load_value(input logic [TICK_W-1:0] ticks);
        logic [COUNT_WIDTH-1:0] val;
        if ((ticks >> COUNT_WIDTH) != '0)
        begin
            val = '1;
        end
        else
        begin
            val = COUNT_WIDTH'(ticks);
        end
        if (val == '0)
        begin
            val = COUNT_WIDTH'(1);
        end
        return val;
    endfunction

    function automatic logic [MODE_W-1:0] mode_code(input drive_state_t st);
        logic [MODE_W-1:0] code;
        case (st)
            ST_BACK:     code = MODE_BACK;
            ST_TURN:     code = MODE_TURN;
            ST_STRAIGHT: code = MODE_STRAIGHT;
            default:     code = MODE_STOP;
        endcase
        return code;
    endfunction

endpackage

// File: design/oads_cfg.sv
// Configuration register file of the drive sequencer.
// Depends on oads_pkg for register indexes, reset values and the config struct.
module oads_cfg
    import oads_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output oads_cfg_t              cfg
);

    oads_cfg_t cfg_reg;
    oads_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_NEAR_THRESHOLD:  cfg_next.near_threshold        = cfg_data[RANGE_W-1:0];
                CFG_BACK_TICKS:      cfg_next.back_ticks            = cfg_data[TICK_W-1:0];
                CFG_TURN_TICKS:      cfg_next.turn_ticks            = cfg_data[TICK_W-1:0];
                CFG_CRUISE_DUTY:     cfg_next.cruise_duty           = cfg_data[DUTY_W-1:0];
                CFG_REVERSE_DUTY:    cfg_next.reverse_duty          = cfg_data[DUTY_W-1:0];
                CFG_TURN_LEFT_DUTY:  cfg_next.turn_left_wheel_duty  = cfg_data[DUTY_W-1:0];
                CFG_TURN_RIGHT_DUTY: cfg_next.turn_right_wheel_duty = cfg_data[DUTY_W-1:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.near_threshold        <= RST_NEAR_THRESHOLD;
            cfg_reg.back_ticks            <= RST_BACK_TICKS;
            cfg_reg.turn_ticks            <= RST_TURN_TICKS;
            cfg_reg.cruise_duty           <= RST_CRUISE_DUTY;
            cfg_reg.reverse_duty          <= RST_REVERSE_DUTY;
            cfg_reg.turn_left_wheel_duty  <= RST_TURN_LEFT_DUTY;
            cfg_reg.turn_right_wheel_duty <= RST_TURN_RIGHT_DUTY;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: design/oads_core.sv
// Drive mode state machine and countdown, with duty selection for the next mode.
// Depends on oads_pkg for the state encoding, config struct and load helper.
module oads_core
    import oads_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     step,
    input  logic                     op,
    input  logic [RANGE_W-1:0]       range_cm,
    input  oads_cfg_t                cfg,
    output logic [MODE_W-1:0]        mode,
    output logic signed [DUTY_W-1:0] left_duty,
    output logic signed [DUTY_W-1:0] right_duty,
    output logic                     changed,
    output oads_stat_t               stat
);

    drive_state_t           state_reg;
    drive_state_t           state_next;
    logic [COUNT_WIDTH-1:0] count_reg;
    logic [COUNT_WIDTH-1:0] count_next;
    logic [COUNT_WIDTH-1:0] count_dec;
    logic                   near;

    assign near      = range_cm < cfg.near_threshold;
    assign count_dec = count_reg - COUNT_WIDTH'(1);

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        if (!op)
        begin
            if (near)
            begin
                case (state_reg)
                    ST_STOP:
                    begin
                        state_next = ST_BACK;
                        count_next = load_value(cfg.back_ticks);
                    end
                    ST_TURN, ST_STRAIGHT:
                    begin
                        state_next = ST_STOP;
                        count_next = '0;
                    end
                    default:
                    begin
                        state_next = state_reg;
                    end
                endcase
            end
            else if (state_reg == ST_STOP)
            begin
                state_next = ST_STRAIGHT;
            end
        end
        else if (count_reg != '0)
        begin
            count_next = count_dec;
            if (count_dec == '0)
            begin
                case (state_reg)
                    ST_BACK:
                    begin
                        state_next = ST_TURN;
                        count_next = load_value(cfg.turn_ticks);
                    end
                    ST_TURN:
                    begin
                        state_next = ST_STRAIGHT;
                    end
                    default:
                    begin
                        state_next = state_reg;
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        case (state_next)
            ST_BACK:
            begin
                left_duty  = cfg.reverse_duty;
                right_duty = cfg.reverse_duty;
            end
            ST_TURN:
            begin
                left_duty  = cfg.turn_left_wheel_duty;
                right_duty = cfg.turn_right_wheel_duty;
            end
            ST_STRAIGHT:
            begin
                left_duty  = cfg.cruise_duty;
                right_duty = cfg.cruise_duty;
            end
            default:
            begin
                left_duty  = '0;
                right_duty = '0;
            end
        endcase
    end

    assign mode    = mode_code(state_next);
    assign changed = state_next != state_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_STOP;
            count_reg <= '0;
        end
        else if (step)
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    assign stat.state      = state_reg;
    assign stat.count_zero = count_reg == '0;

endmodule

// File: design/obstacle_avoid_drive_sequencer_unit.sv
// Obstacle avoidance drive sequencer: input register, mode/countdown step, result register.
// Each item is registered in the input register, then its result in the result register.
// Throughput: one item per cycle; a stalled result holds the item in the input register,
// and the input stalls only while both registers are full and the result is stalled.
// Reset: mode stopped, countdown idle, both stages empty, registers at defaults.
// Depends on oads_pkg, oads_cfg and oads_core.
module obstacle_avoid_drive_sequencer_unit
    import oads_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CFG_INDEX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic                     op,
    input  logic [RANGE_W-1:0]       range_cm,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [MODE_W-1:0]        mode,
    output logic signed [DUTY_W-1:0] left_duty,
    output logic signed [DUTY_W-1:0] right_duty,
    output logic                     changed
);

    oads_cfg_t                cfg;
    oads_stat_t               stat;

    logic                     in_valid_reg;
    logic                     op_reg;
    logic [RANGE_W-1:0]       range_reg;

    logic                     out_valid_reg;
    logic [MODE_W-1:0]        mode_reg;
    logic signed [DUTY_W-1:0] left_reg;
    logic signed [DUTY_W-1:0] right_reg;
    logic                     changed_reg;

    logic                     advance;
    logic                     step;
    logic [MODE_W-1:0]        mode_next;
    logic signed [DUTY_W-1:0] left_next;
    logic signed [DUTY_W-1:0] right_next;
    logic                     changed_next;

    oads_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    oads_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .op         (op_reg),
        .range_cm   (range_reg),
        .cfg        (cfg),
        .mode       (mode_next),
        .left_duty  (left_next),
        .right_duty (right_next),
        .changed    (changed_next),
        .stat       (stat)
    );

    assign advance  = !out_valid_reg || !out_stall;
    assign step     = in_valid_reg && advance;
    assign in_stall = in_valid_reg && !advance;

    // capture a new item whenever the input stage is free or moving on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            op_reg    <= op;
            range_reg <= range_cm;
        end
    end

    // hold the result while stalled
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            mode_reg    <= mode_next;
            left_reg    <= left_next;
            right_reg   <= right_next;
            changed_reg <= changed_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign mode       = mode_reg;
    assign left_duty  = left_reg;
    assign right_duty = right_reg;
    assign changed    = changed_reg;

    a_count_matches_mode: assert property (@(posedge clk) disable iff (!rst_n)
        stat.count_zero == (stat.state == ST_STOP || stat.state == ST_STRAIGHT))
        else $error("countdown idle state disagrees with drive mode");

    a_stop_duties_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && mode_reg == MODE_STOP) |-> (left_reg == '0 && right_reg == '0))
        else $error("stopped result carries nonzero duty");

    a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid_reg && out_stall && in_valid_reg))
        else $error("input stalled without a blocked result");

    a_step_updates_result: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> (out_valid_reg && mode_reg == mode_code(stat.state)))
        else $error("result mode does not follow the stepped state");

endmodule
